### rtl/tcpseg_pkg.sv
package tcpseg_pkg;

    localparam int MAX_PAYLOAD    = 2048;
    localparam int CNT_W          = $clog2(MAX_PAYLOAD + 1);
    localparam int POS_W          = 12;

    localparam int IP_HLEN        = 20;
    localparam int TCP_HLEN_BASE  = 20;
    localparam int TCP_HLEN_SYN   = 24;
    localparam int SYN_BIT        = 1;

    localparam int QDEPTH         = 4;
    localparam int QAW            = $clog2(QDEPTH);
    localparam int QCW            = $clog2(QDEPTH + 1);

    localparam logic [7:0]  IP_VER_IHL   = 8'h45;
    localparam logic [7:0]  IP_FLAGS_DF  = 8'h40;
    localparam logic [7:0]  IP_TTL       = 8'd64;
    localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
    localparam logic [7:0]  TCP_WIN_HI   = 8'hFA;
    localparam logic [7:0]  TCP_WIN_LO   = 8'hF0;
    localparam logic [7:0]  OPT_KIND_MSS = 8'h02;
    localparam logic [7:0]  OPT_LEN_MSS  = 8'h04;
    localparam logic [7:0]  MSS_HI       = 8'h05;
    localparam logic [7:0]  MSS_LO       = 8'hB4;

    // one queue entry: an optional payload beat and an optional header job
    typedef struct packed {
        logic             has_pl;
        logic [POS_W-1:0] pl_pos;
        logic [7:0]       pl_byte;
        logic             has_hdr;
        logic             ovf;
        logic [15:0]      psum;
        logic [15:0]      tcp_len;
        logic [31:0]      src;
        logic [31:0]      dst;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [31:0]      seq;
        logic [31:0]      ack;
        logic [7:0]       flags;
    } seg_entry_t;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

### rtl/tcpseg_front.sv
module tcpseg_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic                      q_full,
    input  logic [7:0]                payload_byte,
    input  logic                      has_byte,
    input  logic                      end_of_packet,
    input  logic [31:0]               src_addr,
    input  logic [31:0]               dst_addr,
    input  logic [15:0]               tcp_sport,
    input  logic [15:0]               tcp_dport,
    input  logic [31:0]               seq_number,
    input  logic [31:0]               ack_number,
    input  logic [7:0]                tcp_flag_bits,
    output logic                      q_push,
    output tcpseg_pkg::seg_entry_t    q_data
);
    import tcpseg_pkg::*;

    logic [15:0]      sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       pend_reg, pend_next;
    logic             odd_reg, odd_next;
    logic             ovf_reg, ovf_next;

    logic             accept;
    logic             take;
    logic             drop;
    logic             syn;
    logic [POS_W-1:0] pl_base;
    logic [15:0]      tcp_hlen;

    always_comb
    begin
        accept   = push && !q_full;
        take     = accept && has_byte && (count_reg < CNT_W'(MAX_PAYLOAD));
        drop     = accept && has_byte && !(count_reg < CNT_W'(MAX_PAYLOAD));
        syn      = tcp_flag_bits[SYN_BIT];
        pl_base  = syn ? POS_W'(IP_HLEN + TCP_HLEN_SYN) : POS_W'(IP_HLEN + TCP_HLEN_BASE);
        tcp_hlen = syn ? 16'(TCP_HLEN_SYN) : 16'(TCP_HLEN_BASE);

        sum_next   = sum_reg;
        pend_next  = pend_reg;
        odd_next   = odd_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg | drop;
        if (take)
        begin
            count_next = count_reg + CNT_W'(1);
            if (odd_reg)
            begin
                sum_next  = ones_add(sum_reg, {pend_reg, payload_byte});
                pend_next = 8'd0;
                odd_next  = 1'b0;
            end
            else
            begin
                pend_next = payload_byte;
                odd_next  = 1'b1;
            end
        end

        q_push          = take || (accept && end_of_packet);
        q_data.has_pl   = take;
        q_data.pl_pos   = pl_base + POS_W'(count_reg);
        q_data.pl_byte  = payload_byte;
        q_data.has_hdr  = end_of_packet;
        q_data.ovf      = ovf_next;
        q_data.psum     = odd_next ? ones_add(sum_next, {pend_next, 8'd0}) : sum_next;
        q_data.tcp_len  = tcp_hlen + 16'(count_next);
        q_data.src      = src_addr;
        q_data.dst      = dst_addr;
        q_data.sport    = tcp_sport;
        q_data.dport    = tcp_dport;
        q_data.seq      = seq_number;
        q_data.ack      = ack_number;
        q_data.flags    = tcp_flag_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            pend_reg  <= '0;
            odd_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_packet)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                pend_reg  <= '0;
                odd_reg   <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                pend_reg  <= pend_next;
                odd_reg   <= odd_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

### rtl/tcpseg_fifo.sv
module tcpseg_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  tcpseg_pkg::seg_entry_t    wr_data,
    input  logic                      rd_en,
    output tcpseg_pkg::seg_entry_t    rd_data,
    output logic                      full,
    output logic                      empty
);
    import tcpseg_pkg::*;

    seg_entry_t     mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == QCW'(QDEPTH));
        empty       = (count_reg == '0);
        rd_data     = mem_reg[rd_ptr_reg];
        wr_ptr_next = wr_en ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + QCW'(1);
        else if (!wr_en && rd_en)
            count_next = count_reg - QCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!full || rd_en))
        else $error("queue written while full");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("queue read while empty");

endmodule

### rtl/tcpseg_back.sv
module tcpseg_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  tcpseg_pkg::seg_entry_t    q_data,
    output logic                      q_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [tcpseg_pkg::POS_W-1:0] position,
    output logic [7:0]                out_byte,
    output logic                      is_header,
    output logic                      overflow,
    output logic                      final_res
);
    import tcpseg_pkg::*;

    seg_entry_t       cur_reg, cur_next;
    logic             pl_pend_reg, pl_pend_next;
    logic             hdr_act_reg, hdr_act_next;
    logic [4:0]       step_reg, step_next;
    logic [5:0]       eidx_reg, eidx_next;
    logic [15:0]      ip_acc_reg, ip_acc_next;
    logic [15:0]      tcp_acc_reg, tcp_acc_next;

    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_hdr_reg, out_hdr_next;
    logic             out_ovf_reg, out_ovf_next;
    logic             out_fin_reg, out_fin_next;

    logic             syn;
    logic [5:0]       hlen;
    logic [5:0]       tcp_hlen;
    logic [4:0]       nsteps;
    logic [15:0]      total;
    logic [15:0]      ip_word;
    logic [15:0]      tcp_word;
    logic             slot_free;
    logic             gate_ok;
    logic             emit_pl;
    logic             emit_hdr;
    logic             last_hdr;
    logic             done_now;
    logic             busy;
    logic             load;
    logic [7:0]       hbyte;

    function automatic logic [7:0] hdr_byte(
        input seg_entry_t e, input logic [5:0] idx, input logic [15:0] tot,
        input logic [7:0] doff, input logic [15:0] ipck, input logic [15:0] tcpck);
        logic [7:0] b;
        unique case (idx) inside
            6'd0:  b = IP_VER_IHL;
            6'd2:  b = tot[15:8];
            6'd3:  b = tot[7:0];
            6'd6:  b = IP_FLAGS_DF;
            6'd8:  b = IP_TTL;
            6'd9:  b = IP_PROTO_TCP;
            6'd10: b = ipck[15:8];
            6'd11: b = ipck[7:0];
            6'd12: b = e.src[31:24];
            6'd13: b = e.src[23:16];
            6'd14: b = e.src[15:8];
            6'd15: b = e.src[7:0];
            6'd16: b = e.dst[31:24];
            6'd17: b = e.dst[23:16];
            6'd18: b = e.dst[15:8];
            6'd19: b = e.dst[7:0];
            6'd20: b = e.sport[15:8];
            6'd21: b = e.sport[7:0];
            6'd22: b = e.dport[15:8];
            6'd23: b = e.dport[7:0];
            6'd24: b = e.seq[31:24];
            6'd25: b = e.seq[23:16];
            6'd26: b = e.seq[15:8];
            6'd27: b = e.seq[7:0];
            6'd28: b = e.ack[31:24];
            6'd29: b = e.ack[23:16];
            6'd30: b = e.ack[15:8];
            6'd31: b = e.ack[7:0];
            6'd32: b = doff;
            6'd33: b = e.flags;
            6'd34: b = TCP_WIN_HI;
            6'd35: b = TCP_WIN_LO;
            6'd36: b = tcpck[15:8];
            6'd37: b = tcpck[7:0];
            6'd40: b = OPT_KIND_MSS;
            6'd41: b = OPT_LEN_MSS;
            6'd42: b = MSS_HI;
            6'd43: b = MSS_LO;
            6'd1, 6'd4, 6'd5, 6'd7, 6'd38, 6'd39: b = 8'd0;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    always_comb
    begin
        syn      = cur_reg.flags[SYN_BIT];
        tcp_hlen = syn ? 6'(TCP_HLEN_SYN) : 6'(TCP_HLEN_BASE);
        hlen     = 6'(IP_HLEN) + tcp_hlen;
        nsteps   = syn ? 5'd18 : 5'd16;
        total    = 16'(IP_HLEN) + cur_reg.tcp_len;

        unique case (step_reg[2:0])
            3'd0:    ip_word = {IP_VER_IHL, 8'd0};
            3'd1:    ip_word = total;
            3'd2:    ip_word = {IP_FLAGS_DF, 8'd0};
            3'd3:    ip_word = {IP_TTL, IP_PROTO_TCP};
            3'd4:    ip_word = cur_reg.src[31:16];
            3'd5:    ip_word = cur_reg.src[15:0];
            3'd6:    ip_word = cur_reg.dst[31:16];
            3'd7:    ip_word = cur_reg.dst[15:0];
            default: ip_word = 16'd0;
        endcase

        unique case (step_reg)
            5'd0:    tcp_word = cur_reg.src[31:16];
            5'd1:    tcp_word = cur_reg.src[15:0];
            5'd2:    tcp_word = cur_reg.dst[31:16];
            5'd3:    tcp_word = cur_reg.dst[15:0];
            5'd4:    tcp_word = {8'd0, IP_PROTO_TCP};
            5'd5:    tcp_word = cur_reg.tcp_len;
            5'd6:    tcp_word = cur_reg.sport;
            5'd7:    tcp_word = cur_reg.dport;
            5'd8:    tcp_word = cur_reg.seq[31:16];
            5'd9:    tcp_word = cur_reg.seq[15:0];
            5'd10:   tcp_word = cur_reg.ack[31:16];
            5'd11:   tcp_word = cur_reg.ack[15:0];
            5'd12:   tcp_word = {tcp_hlen[5:2], 4'd0, cur_reg.flags};
            5'd13:   tcp_word = {TCP_WIN_HI, TCP_WIN_LO};
            5'd16:   tcp_word = {OPT_KIND_MSS, OPT_LEN_MSS};
            5'd17:   tcp_word = {MSS_HI, MSS_LO};
            default: tcp_word = 16'd0;
        endcase

        hbyte = hdr_byte(cur_reg, eidx_reg, total, {tcp_hlen[5:2], 4'd0},
                         ~ip_acc_reg, ~tcp_acc_reg);

        // checksum bytes wait for their sums
        gate_ok   = (eidx_reg < 6'd10 || step_reg >= 5'd8)
                 && (eidx_reg < 6'd36 || step_reg >= nsteps);
        slot_free = !out_valid_reg || pop;
        emit_pl   = slot_free && pl_pend_reg;
        emit_hdr  = slot_free && !pl_pend_reg && hdr_act_reg && gate_ok;
        last_hdr  = (eidx_reg == hlen - 6'd1);
        done_now  = (emit_pl && !hdr_act_reg) || (emit_hdr && last_hdr);
        busy      = pl_pend_reg || hdr_act_reg;
        load      = !q_empty && (!busy || done_now);
        q_pop     = load;

        cur_next     = cur_reg;
        pl_pend_next = pl_pend_reg;
        hdr_act_next = hdr_act_reg;
        step_next    = step_reg;
        eidx_next    = eidx_reg;
        ip_acc_next  = ip_acc_reg;
        tcp_acc_next = tcp_acc_reg;

        if (hdr_act_reg && step_reg < nsteps)
        begin
            step_next    = step_reg + 5'd1;
            tcp_acc_next = ones_add(tcp_acc_reg, tcp_word);
            if (step_reg < 5'd8)
                ip_acc_next = ones_add(ip_acc_reg, ip_word);
        end
        if (emit_pl)
            pl_pend_next = 1'b0;
        if (emit_hdr)
        begin
            eidx_next = eidx_reg + 6'd1;
            if (last_hdr)
                hdr_act_next = 1'b0;
        end
        if (load)
        begin
            cur_next     = q_data;
            pl_pend_next = q_data.has_pl;
            hdr_act_next = q_data.has_hdr;
            step_next    = '0;
            eidx_next    = '0;
            ip_acc_next  = '0;
            tcp_acc_next = q_data.psum;
        end

        out_valid_next = out_valid_reg && !pop;
        out_pos_next   = out_pos_reg;
        out_byte_next  = out_byte_reg;
        out_hdr_next   = out_hdr_reg;
        out_ovf_next   = out_ovf_reg;
        out_fin_next   = out_fin_reg;
        if (emit_pl)
        begin
            out_valid_next = 1'b1;
            out_pos_next   = cur_reg.pl_pos;
            out_byte_next  = cur_reg.pl_byte;
            out_hdr_next   = 1'b0;
            out_ovf_next   = 1'b0;
            out_fin_next   = 1'b0;
        end
        else if (emit_hdr)
        begin
            out_valid_next = 1'b1;
            out_pos_next   = POS_W'(eidx_reg);
            out_byte_next  = hbyte;
            out_hdr_next   = 1'b1;
            out_ovf_next   = cur_reg.ovf;
            out_fin_next   = last_hdr;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        ip_acc_reg   <= ip_acc_next;
        tcp_acc_reg  <= tcp_acc_next;
        out_pos_reg  <= out_pos_next;
        out_byte_reg <= out_byte_next;
        out_hdr_reg  <= out_hdr_next;
        out_ovf_reg  <= out_ovf_next;
        out_fin_reg  <= out_fin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pl_pend_reg   <= 1'b0;
            hdr_act_reg   <= 1'b0;
            step_reg      <= '0;
            eidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pl_pend_reg   <= pl_pend_next;
            hdr_act_reg   <= hdr_act_next;
            step_reg      <= step_next;
            eidx_reg      <= eidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty     = !out_valid_reg;
    assign position  = out_pos_reg;
    assign out_byte  = out_byte_reg;
    assign is_header = out_hdr_reg;
    assign overflow  = out_ovf_reg;
    assign final_res = out_fin_reg;

    a_final_is_last_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fin_reg) |->
            (out_hdr_reg && (out_pos_reg == POS_W'(39) || out_pos_reg == POS_W'(43))))
        else $error("final beat is not the last header byte");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_act_reg |-> (step_reg <= nsteps))
        else $error("checksum step past end");

    a_final_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_hdr && last_hdr) |-> (step_reg == nsteps && !pl_pend_reg))
        else $error("header closed before checksum done");

    a_pl_beat_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hdr_reg) |-> (!out_ovf_reg && !out_fin_reg))
        else $error("payload beat carries header flags");

endmodule

### rtl/tcp_ipv4_segment_builder_unit.sv
// IPv4/TCP segment builder. Payload bytes go in one beat per clock while full is
// low and come out one beat per clock while pop takes them, at their packet
// position (40 or 44 plus index; 44 with SYN), with a running one's-complement
// sum kept on the way in. The item flagged end_of_packet is followed by 40 header
// beats (44 when SYN adds the MSS option), one per clock while pop takes them,
// positions 0 upward, final_res on the last. Both checksums are built by a
// one-word-per-clock sequencer that runs alongside the header output. A 4-entry
// queue sits between the input side and the output side; input stalls (full) only
// while the queue is full. Payload beyond 2048 bytes is dropped and reported
// through overflow on the header beats.
module tcp_ipv4_segment_builder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     payload_byte,
    input  logic                           has_byte,
    input  logic                           end_of_packet,
    input  logic [31:0]                    src_addr,
    input  logic [31:0]                    dst_addr,
    input  logic [15:0]                    tcp_sport,
    input  logic [15:0]                    tcp_dport,
    input  logic [31:0]                    seq_number,
    input  logic [31:0]                    ack_number,
    input  logic [7:0]                     tcp_flag_bits,
    output logic                           empty,
    input  logic                           pop,
    output logic [tcpseg_pkg::POS_W-1:0]   position,
    output logic [7:0]                     out_byte,
    output logic                           is_header,
    output logic                           overflow,
    output logic                           final_res
);
    import tcpseg_pkg::*;

    seg_entry_t wr_data;
    seg_entry_t rd_data;
    logic       wr_en;
    logic       rd_en;
    logic       q_empty;

    tcpseg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .q_full        (full),
        .payload_byte  (payload_byte),
        .has_byte      (has_byte),
        .end_of_packet (end_of_packet),
        .src_addr      (src_addr),
        .dst_addr      (dst_addr),
        .tcp_sport     (tcp_sport),
        .tcp_dport     (tcp_dport),
        .seq_number    (seq_number),
        .ack_number    (ack_number),
        .tcp_flag_bits (tcp_flag_bits),
        .q_push        (wr_en),
        .q_data        (wr_data)
    );

    tcpseg_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .full    (full),
        .empty   (q_empty)
    );

    tcpseg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (rd_data),
        .q_pop     (rd_en),
        .pop       (pop),
        .empty     (empty),
        .position  (position),
        .out_byte  (out_byte),
        .is_header (is_header),
        .overflow  (overflow),
        .final_res (final_res)
    );

endmodule
